[rtl/core/qsh_pkg.sv]
// Package for the quantising sample-and-hold: channel item types, register map,
// source and hold codes, and the serial divider interface structs.
// No dependencies; qsh_cfg, qsh_sdiv and the top level import it.
`timescale 1ns / 1ps
`default_nettype none

package qsh_pkg;

  // Full scale of a reading; noise words are masked to it
  localparam logic [15:0] FULL_SCALE = 16'd4095;

  // Serial divider widths: dividend and quotient, divisor and remainder
  localparam int unsigned DIV_W = 16;
  localparam int unsigned DVS_W = 15;
  localparam int unsigned CNT_W = $clog2(DIV_W + 1);

  // Configuration port
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_SOURCE_SELECT   = 3'd0;
  localparam logic [IDX_W-1:0] REG_HOLD_MODE       = 3'd1;
  localparam logic [IDX_W-1:0] REG_QUANT_STEPS     = 3'd2;
  localparam logic [IDX_W-1:0] REG_SIGNAL_PATCHED  = 3'd3;
  localparam logic [IDX_W-1:0] REG_TRIGGER_PATCHED = 3'd4;

  // Source select codes; the unused code acts as noise
  localparam logic [1:0] SRC_AUTO   = 2'd0;
  localparam logic [1:0] SRC_SIGNAL = 2'd1;
  localparam logic [1:0] SRC_NOISE  = 2'd2;

  // Hold modes
  localparam logic HOLD_SAMPLE = 1'b0;
  localparam logic HOLD_TRACK  = 1'b1;

  typedef struct packed {
    logic [1:0] source_select;
    logic       hold_mode;
    logic [7:0] quant_steps;
    logic       signal_patched;
    logic       trigger_patched;
  } cfg_t;

  typedef struct packed {
    logic               gate_level;
    logic signed [15:0] signal_value;
    logic        [15:0] noise_word;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] held_cv;
    logic        [15:0] capture_count;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DVS_W-1:0] remainder;
  } div_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GRID,
    ST_LEVEL,
    ST_FINISH
  } state_e;

endpackage

`default_nettype wire

[rtl/core/qsh_stream_if.sv]
// Valid/ready stream channel carrying one payload item per request.
// The payload type is set at instantiation, normally a struct from qsh_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface qsh_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

[rtl/core/qsh_cfg.sv]
// APB-style configuration registers of the quantising sample-and-hold.
// Depends on qsh_pkg for the register map and the cfg_t struct.
`timescale 1ns / 1ps
`default_nettype none

module qsh_cfg (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [qsh_pkg::ADDR_W-1:0] paddr,
  input  wire logic [qsh_pkg::DATA_W-1:0] pwdata,
  output      logic [qsh_pkg::DATA_W-1:0] prdata,
  output      logic                       pready,
  output      qsh_pkg::cfg_t              cfg_o
);
  import qsh_pkg::*;

  cfg_t             cfg_q, cfg_d;
  logic             wr_en;
  logic [IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[ADDR_W-1:2];

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_SOURCE_SELECT:   cfg_d.source_select   = pwdata[1:0];
        REG_HOLD_MODE:       cfg_d.hold_mode       = pwdata[0];
        REG_QUANT_STEPS:     cfg_d.quant_steps     = pwdata[7:0];
        REG_SIGNAL_PATCHED:  cfg_d.signal_patched  = pwdata[0];
        REG_TRIGGER_PATCHED: cfg_d.trigger_patched = pwdata[0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read-back mux
  always_comb begin
    case (idx)
      REG_SOURCE_SELECT:   prdata = {30'd0, cfg_q.source_select};
      REG_HOLD_MODE:       prdata = {31'd0, cfg_q.hold_mode};
      REG_QUANT_STEPS:     prdata = {24'd0, cfg_q.quant_steps};
      REG_SIGNAL_PATCHED:  prdata = {31'd0, cfg_q.signal_patched};
      REG_TRIGGER_PATCHED: prdata = {31'd0, cfg_q.trigger_patched};
      default:             prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[rtl/core/qsh_sdiv.sv]
// Bit-serial restoring divider: one quotient bit per cycle over the DIV_W-bit dividend.
// Depends on qsh_pkg for widths and the div_req_t / div_rsp_t structs.
`timescale 1ns / 1ps
`default_nettype none

module qsh_sdiv (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire qsh_pkg::div_req_t req_i,
  output      qsh_pkg::div_rsp_t rsp_o
);
  import qsh_pkg::*;

  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] dvs_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DVS_W:0]   shifted;
  logic [DVS_W+1:0] diff;
  logic             fits;

  // One restoring step: shift in the next dividend bit, try the subtract
  assign shifted = {rem_q, quo_q[DIV_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
  assign fits    = ~diff[DVS_W+1];

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.dividend;
      cnt_d  = CNT_W'(DIV_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Shift registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (req_i.start) begin
      dvs_q <= req_i.divisor;
    end
  end

  assign rsp_o.busy      = busy_q;
  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

`default_nettype wire

[rtl/core/quantising_sample_and_hold_top.sv]
// Quantising sample-and-hold, top level: request channels, control FSM and hold state.
// Depends on qsh_pkg, qsh_stream_if, qsh_cfg and qsh_sdiv.
//
// Every input request yields exactly one result: the held value and the count of
// rising-gate captures. Requests are taken one at a time. A request that captures
// nothing, or captures with quant_steps below 2, goes from acceptance straight to
// the finish state, where it waits for the result register to be free. A quantised
// capture first runs two divisions on one bit-serial divider (grid pitch, then
// grid level). The next request is taken the cycle after the result register loads.
// The result register lets the next request be accepted while a result still waits
// downstream. Configuration is written over the APB port while the block is idle:
// the user must keep to this, as the block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module quantising_sample_and_hold_top (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [qsh_pkg::ADDR_W-1:0] paddr,
  input  wire logic [qsh_pkg::DATA_W-1:0] pwdata,
  output      logic [qsh_pkg::DATA_W-1:0] prdata,
  output      logic                       pready,
  qsh_stream_if.sink                      in_i,
  qsh_stream_if.source                    out_o
);
  import qsh_pkg::*;

  cfg_t      cfg;
  div_req_t  div_req;
  div_rsp_t  div_rsp;
  in_item_t  in_item;

  state_e      state_q, state_d;
  logic        prev_gate_q, prev_gate_d;
  logic [15:0] captures_q, captures_d;
  logic [15:0] held_q, held_d;
  logic [15:0] raw_q, raw_d;
  logic [15:0] dvd_q, dvd_d;
  logic        neg_q, neg_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_data_q, out_data_d;

  logic        accept;
  logic        level;
  logic        rising;
  logic        capture;
  logic        quantise;
  logic        sig_sel;
  logic [15:0] reading;
  logic [15:0] magnitude;
  logic [15:0] product;
  logic        slot_free;

  qsh_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  qsh_sdiv u_sdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_item      = in_i.payload;
  assign in_i.ready   = (state_q == ST_IDLE);
  assign accept       = in_i.valid & in_i.ready;
  assign slot_free    = ~out_valid_q | out_o.ready;

  // Gate edge and capture decision
  assign level    = cfg.trigger_patched & in_item.gate_level;
  assign rising   = level & ~prev_gate_q;
  assign capture  = (cfg.hold_mode == HOLD_TRACK) ? level : rising;
  assign quantise = (cfg.quant_steps > 8'd1);

  // Reading source: signal, zero when unpatched, or masked noise
  assign sig_sel = (cfg.source_select == SRC_SIGNAL) ||
                   ((cfg.source_select == SRC_AUTO) && cfg.signal_patched);
  assign reading = sig_sel ?
                   (cfg.signal_patched ? in_item.signal_value : 16'd0) :
                   (in_item.noise_word & FULL_SCALE);

  // Level division operand: |raw| + grid/2, and the grid value level*grid
  assign magnitude = raw_q[15] ? (16'd0 - raw_q) : raw_q;
  assign product   = dvd_q - {1'b0, div_rsp.remainder};

  // Next state, divider requests and hold updates
  always_comb begin
    state_d          = state_q;
    prev_gate_d      = prev_gate_q;
    captures_d       = captures_q;
    held_d           = held_q;
    raw_d            = raw_q;
    dvd_d            = dvd_q;
    neg_d            = neg_q;
    div_req.start    = 1'b0;
    div_req.dividend = FULL_SCALE;
    div_req.divisor  = {7'd0, cfg.quant_steps - 8'd1};
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          prev_gate_d = level;
          if (rising) begin
            captures_d = captures_q + 16'd1;
          end
          if (capture) begin
            raw_d = reading;
            if (quantise) begin
              div_req.start = 1'b1;
              state_d       = ST_GRID;
            end else begin
              held_d  = reading;
              state_d = ST_FINISH;
            end
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_GRID: begin
        div_req.dividend = magnitude + {1'b0, div_rsp.quotient[DIV_W-1:1]};
        div_req.divisor  = div_rsp.quotient[DVS_W-1:0];
        if (div_rsp.done) begin
          if (div_rsp.quotient == '0) begin
            held_d  = raw_q;
            state_d = ST_FINISH;
          end else begin
            div_req.start = 1'b1;
            dvd_d         = div_req.dividend;
            neg_d         = raw_q[15];
            state_d       = ST_LEVEL;
          end
        end
      end
      ST_LEVEL: begin
        if (div_rsp.done) begin
          held_d  = neg_q ? (16'd0 - product) : product;
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Result register
  always_comb begin
    out_valid_d = out_valid_q & ~out_o.ready;
    out_data_d  = out_data_q;
    if (state_q == ST_FINISH && slot_free) begin
      out_valid_d              = 1'b1;
      out_data_d.held_cv       = held_q;
      out_data_d.capture_count = captures_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prev_gate_q <= 1'b0;
      captures_q  <= '0;
      held_q      <= '0;
      raw_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prev_gate_q <= prev_gate_d;
      captures_q  <= captures_d;
      held_q      <= held_d;
      raw_q       <= raw_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q      <= dvd_d;
    neg_q      <= neg_d;
    out_data_q <= out_data_d;
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_data_q;

  // Capture count moves only with an accepted request
  a_captures_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.valid && in_i.ready) |=> $stable(captures_q))
    else $error("capture count changed without an accepted request");

  // The divider is never running while the block waits for a request
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !div_rsp.busy)
    else $error("divider busy while idle");

  // Grid division completes into the level division or straight to the result
  a_grid_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_GRID && div_rsp.done) |=>
      (state_q == ST_LEVEL || state_q == ST_FINISH))
    else $error("grid division result lost");

  // Leaving the finish state always posts a result
  a_result_posted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && slot_free) |=> out_valid_q)
    else $error("result not posted");

endmodule

`default_nettype wire
